@@ src/i2cmbe_pkg.sv @@
// Shared types and constants for the I2C master bit engine.
package i2cmbe_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned HALF_W        = 16;
  localparam int unsigned TDATA_W       = 16;

  localparam logic [HALF_W-1:0] HALF_PERIOD_RESET    = 16'd130;
  localparam logic [HALF_W-1:0] STRETCH_TIMEOUT_RESET = 16'd1846;

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_MACK  = 3'd4,
    CMD_MNACK = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_NO_ACK  = 2'd2
  } status_t;

  typedef enum logic {
    REG_HALF_PERIOD = 1'b0,
    REG_STRETCH     = 1'b1
  } reg_idx_t;

  // one input tick, highest field first
  typedef struct packed {
    logic       sda_in;
    logic       scl_in;
    logic [7:0] write_data;
    logic [2:0] command;
    logic       cmd_valid;
  } tick_t;

  // one result, highest field first
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] read_data;
    logic       done_res;
    logic       busy_res;
    logic       sda_release;
    logic       scl_release;
  } result_t;

  typedef struct packed {
    logic [HALF_W-1:0] half_period;
    logic [HALF_W-1:0] stretch_timeout;
  } cfg_t;

endpackage

@@ src/i2cmbe_core.sv @@
// Bus sequencer: advances the engine state by one tick per step.
module i2cmbe_core
  import i2cmbe_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  tick_t   tick,
  input  cfg_t    cfg,
  output result_t res
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST1, PH_ST2, PH_ST3, PH_ST4,
    PH_SP1, PH_SP2, PH_SP3, PH_SP4,
    PH_WR_SETUP, PH_WR_SYNC, PH_WR_HIGH,
    PH_ACK_LOW, PH_ACK_SYNC, PH_ACK_HIGH,
    PH_RD_SYNC, PH_RD_HIGH, PH_RD_LOW,
    PH_MA_SYNC, PH_MA_HIGH
  } phase_t;

  phase_t            phase, phase_next;
  logic [2:0]        active_command, active_command_next;
  logic [7:0]        shift_byte, shift_byte_next;
  logic [3:0]        bit_count, bit_count_next;
  logic [HALF_W-1:0] delay_count, delay_count_next;
  logic [HALF_W-1:0] timeout_count, timeout_count_next;
  logic              scl_drive, scl_drive_next;
  logic              sda_drive, sda_drive_next;
  logic [1:0]        last_status, last_status_next;
  logic [7:0]        read_hold, read_hold_next;
  logic              finished;

  logic       wait_done;
  logic       sync_fail;
  logic       sync_ok;
  logic [3:0] bit_inc;

  assign wait_done = (delay_count <= 16'd1);
  assign sync_fail = (timeout_count == '0);
  assign sync_ok   = !sync_fail && tick.scl_in;
  assign bit_inc   = bit_count + 4'd1;

  always_comb begin
    phase_next          = phase;
    active_command_next = active_command;
    shift_byte_next     = shift_byte;
    bit_count_next      = bit_count;
    delay_count_next    = delay_count;
    timeout_count_next  = timeout_count;
    scl_drive_next      = scl_drive;
    sda_drive_next      = sda_drive;
    last_status_next    = last_status;
    read_hold_next      = read_hold;
    finished            = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        if (tick.cmd_valid && tick.command <= CMD_MNACK) begin
          active_command_next = tick.command;
          case (tick.command)
            CMD_START: begin
              phase_next       = PH_ST1;
              delay_count_next = cfg.half_period;
            end
            CMD_STOP: begin
              phase_next       = PH_SP1;
              delay_count_next = cfg.half_period;
            end
            CMD_WRITE: begin
              shift_byte_next  = tick.write_data;
              bit_count_next   = '0;
              phase_next       = PH_WR_SETUP;
              delay_count_next = cfg.half_period;
            end
            CMD_READ: begin
              shift_byte_next    = '0;
              bit_count_next     = '0;
              sda_drive_next     = 1'b1;
              scl_drive_next     = 1'b1;
              phase_next         = PH_RD_SYNC;
              timeout_count_next = cfg.stretch_timeout;
            end
            default: begin
              sda_drive_next     = (tick.command == CMD_MNACK);
              scl_drive_next     = 1'b1;
              phase_next         = PH_MA_SYNC;
              timeout_count_next = cfg.stretch_timeout;
            end
          endcase
        end
      end
      PH_ST1, PH_ST2, PH_ST3, PH_SP1, PH_SP2, PH_SP3, PH_WR_SETUP, PH_WR_HIGH,
      PH_ACK_LOW, PH_RD_HIGH, PH_RD_LOW, PH_ST4, PH_SP4, PH_ACK_HIGH,
      PH_MA_HIGH: begin
        if (!wait_done) begin
          delay_count_next = delay_count - 16'd1;
        end else begin
          delay_count_next = cfg.half_period;
          case (phase)
            PH_ST1: begin
              scl_drive_next = 1'b1;
              sda_drive_next = 1'b1;
              phase_next     = PH_ST2;
            end
            PH_ST2: begin
              sda_drive_next = 1'b0;
              phase_next     = PH_ST3;
            end
            PH_ST3: begin
              scl_drive_next = 1'b0;
              phase_next     = PH_ST4;
            end
            PH_SP1: begin
              sda_drive_next = 1'b0;
              phase_next     = PH_SP2;
            end
            PH_SP2: begin
              scl_drive_next = 1'b1;
              phase_next     = PH_SP3;
            end
            PH_SP3: begin
              sda_drive_next = 1'b1;
              phase_next     = PH_SP4;
            end
            PH_WR_SETUP: begin
              delay_count_next   = delay_count;
              sda_drive_next     = shift_byte[7];
              scl_drive_next     = 1'b1;
              phase_next         = PH_WR_SYNC;
              timeout_count_next = cfg.stretch_timeout;
            end
            PH_WR_HIGH: begin
              scl_drive_next  = 1'b0;
              shift_byte_next = {shift_byte[6:0], 1'b0};
              bit_count_next  = bit_inc;
              phase_next      = (bit_inc >= 4'(BITS_PER_BYTE)) ? PH_ACK_LOW : PH_WR_SETUP;
            end
            PH_ACK_LOW: begin
              delay_count_next   = delay_count;
              sda_drive_next     = 1'b1;
              scl_drive_next     = 1'b1;
              phase_next         = PH_ACK_SYNC;
              timeout_count_next = cfg.stretch_timeout;
            end
            PH_RD_HIGH: begin
              shift_byte_next = {shift_byte[6:0], tick.sda_in};
              scl_drive_next  = 1'b0;
              phase_next      = PH_RD_LOW;
            end
            PH_RD_LOW: begin
              delay_count_next = delay_count;
              bit_count_next   = bit_inc;
              if (bit_inc >= 4'(BITS_PER_BYTE)) begin
                read_hold_next   = shift_byte;
                last_status_next = ST_OK;
                finished         = 1'b1;
                phase_next       = PH_IDLE;
              end else begin
                sda_drive_next     = 1'b1;
                scl_drive_next     = 1'b1;
                phase_next         = PH_RD_SYNC;
                timeout_count_next = cfg.stretch_timeout;
              end
            end
            PH_ACK_HIGH: begin
              delay_count_next = delay_count;
              scl_drive_next   = 1'b0;
              last_status_next = tick.sda_in ? ST_NO_ACK : ST_OK;
              finished         = 1'b1;
              phase_next       = PH_IDLE;
            end
            PH_MA_HIGH: begin
              delay_count_next = delay_count;
              scl_drive_next   = 1'b0;
              last_status_next = ST_OK;
              finished         = 1'b1;
              phase_next       = PH_IDLE;
            end
            default: begin
              // end of a start or stop sequence
              delay_count_next = delay_count;
              last_status_next = ST_OK;
              finished         = 1'b1;
              phase_next       = PH_IDLE;
            end
          endcase
        end
      end
      PH_WR_SYNC, PH_ACK_SYNC, PH_RD_SYNC: begin
        if (sync_fail) begin
          last_status_next = ST_TIMEOUT;
          finished         = 1'b1;
          phase_next       = PH_IDLE;
        end else if (sync_ok) begin
          delay_count_next = cfg.half_period;
          case (phase)
            PH_WR_SYNC:  phase_next = PH_WR_HIGH;
            PH_ACK_SYNC: phase_next = PH_ACK_HIGH;
            default:     phase_next = PH_RD_HIGH;
          endcase
        end else begin
          timeout_count_next = timeout_count - 16'd1;
        end
      end
      PH_MA_SYNC: begin
        // master ack/nack goes on after a timeout
        if (sync_fail || sync_ok) begin
          delay_count_next = cfg.half_period;
          phase_next       = PH_MA_HIGH;
        end else begin
          timeout_count_next = timeout_count - 16'd1;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      active_command <= '0;
      shift_byte     <= '0;
      bit_count      <= '0;
      delay_count    <= '0;
      timeout_count  <= '0;
      scl_drive      <= 1'b1;
      sda_drive      <= 1'b1;
      last_status    <= '0;
      read_hold      <= '0;
    end else if (step) begin
      phase          <= phase_next;
      active_command <= active_command_next;
      shift_byte     <= shift_byte_next;
      bit_count      <= bit_count_next;
      delay_count    <= delay_count_next;
      timeout_count  <= timeout_count_next;
      scl_drive      <= scl_drive_next;
      sda_drive      <= sda_drive_next;
      last_status    <= last_status_next;
      read_hold      <= read_hold_next;
    end
  end

  always_comb begin
    res.scl_release = scl_drive_next;
    res.sda_release = sda_drive_next;
    res.busy_res    = (phase_next != PH_IDLE);
    res.done_res    = finished;
    res.read_data   = read_hold_next;
    res.status      = last_status_next;
  end

endmodule

@@ src/i2c_master_bit_engine.sv @@
// Top level of the I2C master bit engine: stream ports, config registers, output buffer.
//
// Each transaction on s_axis is one clock tick of the bus engine: it carries the
// sampled SCL/SDA levels and, optionally, a command. Each accepted transaction
// yields exactly one m_axis transaction with the line drives, busy, done, the
// last byte read and the status of the last finished command.
// The engine state advances in the cycle a transaction is accepted; its result
// is registered in the output register, or in the skid stage while m_axis stalls.
// Throughput is one transaction per cycle while m_axis takes results; the limit
// is the single state update per tick in the bus sequencer.
// The result register is backed by a one-entry skid stage, so s_axis still accepts
// one more transaction while m_axis is stalled; with both full, s_axis_tready
// drops until m_axis takes a result.
// Config writes (cfg_index 0: half period, 1: stretch timeout) are always
// accepted and should be made while the engine is idle.
// Reset restores the default timing registers, releases both lines, clears
// status and read data and empties the output buffer.
module i2c_master_bit_engine
  import i2cmbe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,  // cmd_valid, command, write_data, scl_in, sda_in
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,  // scl_release, sda_release, busy_res, done_res,
                                            // read_data, status
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [HALF_W-1:0]  cfg_data
);

  cfg_t    cfg;
  tick_t   tick;
  result_t res;
  result_t out_reg, skid_reg;
  logic    out_valid, skid_valid;
  logic    push, pop;

  assign tick          = s_axis_tdata[$bits(tick_t)-1:0];
  assign s_axis_tready = !skid_valid;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = out_valid && m_axis_tready;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period     <= HALF_PERIOD_RESET;
      cfg.stretch_timeout <= STRETCH_TIMEOUT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HALF_PERIOD: cfg.half_period     <= cfg_data;
        REG_STRETCH:     cfg.stretch_timeout <= cfg_data;
        default:         cfg.half_period     <= cfg.half_period;
      endcase
    end
  end

  i2cmbe_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (push),
    .tick (tick),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_reg    <= skid_reg;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        if (push) begin
          out_reg <= res;
        end
      end
    end else if (push) begin
      skid_reg   <= res;
      skid_valid <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(TDATA_W-$bits(result_t)){1'b0}}, out_reg};

endmodule
